@@ hw/rtl/log_mass_per_charge_channel_assert.svh @@
// ----------------------------------------------------------------------------
// log_mass_per_charge_channel_assert.svh
// Assertion macros used by the log m/q channel RTL.
// ----------------------------------------------------------------------------
`ifndef LOG_MASS_PER_CHARGE_CHANNEL_ASSERT_SVH
`define LOG_MASS_PER_CHARGE_CHANNEL_ASSERT_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define LMQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmq assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmq assertion failed");

`endif

@@ hw/rtl/lmq_pkg.sv @@
// ----------------------------------------------------------------------------
// lmq_pkg
// Types, register indexes and the ln mantissa table for the log m/q channel.
// ----------------------------------------------------------------------------
package lmq_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOF_UNDER = 3'd1,
    ST_TOF_OVER  = 3'd2,
    ST_MQ_UNDER  = 3'd3,
    ST_MQ_OVER   = 3'd4
  } status_t;

  localparam logic [2:0] REG_TOF_MIN    = 3'd0;
  localparam logic [2:0] REG_TOF_MAX    = 3'd1;
  localparam logic [2:0] REG_TOF_OFFSET = 3'd2;
  localparam logic [2:0] REG_TOF_DAC    = 3'd3;
  localparam logic [2:0] REG_COEF_CONST = 3'd4;
  localparam logic [2:0] REG_COEF_W     = 3'd5;
  localparam logic [2:0] REG_COEF_U     = 3'd6;
  localparam logic [2:0] REG_MQ_WINDOW  = 3'd7;

  localparam int unsigned CFG_W = 48;

  // ln(2) in Q.16
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  // -1.0 in Q8.16, 25 bit two's complement
  localparam logic [24:0] U_NEG_ONE = 25'h1FF0000;

  // round(65536 * ln(1 + k/32)), k = 0..32
  function automatic logic [15:0] ln_tab(input logic [5:0] k);
    logic [15:0] v;
    unique case (k)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd2017;
      6'd2:  v = 16'd3973;
      6'd3:  v = 16'd5873;
      6'd4:  v = 16'd7719;
      6'd5:  v = 16'd9515;
      6'd6:  v = 16'd11262;
      6'd7:  v = 16'd12965;
      6'd8:  v = 16'd14624;
      6'd9:  v = 16'd16242;
      6'd10: v = 16'd17821;
      6'd11: v = 16'd19364;
      6'd12: v = 16'd20870;
      6'd13: v = 16'd22343;
      6'd14: v = 16'd23783;
      6'd15: v = 16'd25193;
      6'd16: v = 16'd26573;
      6'd17: v = 16'd27924;
      6'd18: v = 16'd29248;
      6'd19: v = 16'd30546;
      6'd20: v = 16'd31818;
      6'd21: v = 16'd33067;
      6'd22: v = 16'd34292;
      6'd23: v = 16'd35494;
      6'd24: v = 16'd36675;
      6'd25: v = 16'd37835;
      6'd26: v = 16'd38975;
      6'd27: v = 16'd40095;
      6'd28: v = 16'd41196;
      6'd29: v = 16'd42280;
      6'd30: v = 16'd43345;
      6'd31: v = 16'd44394;
      6'd32: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/log_mass_per_charge_channel.sv @@
// ----------------------------------------------------------------------------
// log_mass_per_charge_channel
// Per ion event: TOF window check, fixed-point ln of the TOF term, linear
// calibration to a Q16.8 log m/q channel and output window check.
// ----------------------------------------------------------------------------
//  channel | ports                                   | beat marked by
//  --------+-----------------------------------------+--------------------
//  input   | in_tof_channel, in_log_energy           | start && !busy
//  result  | out_mq_value, out_status                | out_valid (1 cycle)
//  config  | cfg_index, cfg_wdata                    | cfg_we
//
// Seven register stages; one beat enters every cycle, busy is always low.
// A result passes stages A to F and the output register before it is driven
// on out_*. The stage count is set by the ln interpolation and the two
// calibration multipliers (32-bit coefficients), each followed by a register.
// Synchronous reset clears the stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module log_mass_per_charge_channel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [9:0]                          in_tof_channel,
  input  logic signed [23:0]                  in_log_energy,
  output logic                                out_valid,
  output logic signed [23:0]                  out_mq_value,
  output logic [2:0]                          out_status,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [lmq_pkg::CFG_W-1:0]           cfg_wdata
);

  // configuration registers
  logic [9:0]  tof_min_r;
  logic [9:0]  tof_max_r;
  logic [15:0] tof_offset_r;
  logic [23:0] tof_dac_r;
  logic [31:0] coef_const_r;
  logic [31:0] coef_w_r;
  logic [31:0] coef_u_r;
  logic [47:0] mq_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tof_min_r    <= 10'd0;
      tof_max_r    <= 10'h3FF;
      tof_offset_r <= 16'd0;
      tof_dac_r    <= 24'd0;
      coef_const_r <= 32'd0;
      coef_w_r     <= 32'h0001_0000;
      coef_u_r     <= 32'h0001_0000;
      mq_window_r  <= 48'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmq_pkg::REG_TOF_MIN:    tof_min_r    <= cfg_wdata[9:0];
        lmq_pkg::REG_TOF_MAX:    tof_max_r    <= cfg_wdata[9:0];
        lmq_pkg::REG_TOF_OFFSET: tof_offset_r <= cfg_wdata[15:0];
        lmq_pkg::REG_TOF_DAC:    tof_dac_r    <= cfg_wdata[23:0];
        lmq_pkg::REG_COEF_CONST: coef_const_r <= cfg_wdata[31:0];
        lmq_pkg::REG_COEF_W:     coef_w_r     <= cfg_wdata[31:0];
        lmq_pkg::REG_COEF_U:     coef_u_r     <= cfg_wdata[31:0];
        lmq_pkg::REG_MQ_WINDOW:  mq_window_r  <= cfg_wdata[47:0];
      endcase
    end
  end

  assign busy = 1'b0;

  // stage valid bits
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= start && !busy;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      out_valid_r <= vf_r;
    end
  end

  // ---- stage A: TOF window, x = tof*16 + offset (Q.4)
  lmq_pkg::status_t st_a_r, st_a_nxt;
  logic [15:0]        x_a_r;
  logic               small_a_r;
  logic signed [23:0] w_a_r;
  logic signed [16:0] x_a_nxt;

  always_comb begin
    x_a_nxt = $signed({3'b000, in_tof_channel, 4'b0000}) +
              $signed({tof_offset_r[15], tof_offset_r});
    if (in_tof_channel < tof_min_r) begin
      st_a_nxt = lmq_pkg::ST_TOF_UNDER;
    end else if (in_tof_channel > tof_max_r) begin
      st_a_nxt = lmq_pkg::ST_TOF_OVER;
    end else begin
      st_a_nxt = lmq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    st_a_r    <= st_a_nxt;
    x_a_r     <= x_a_nxt[15:0];
    small_a_r <= (x_a_nxt < 17'sd16);
    w_a_r     <= in_log_energy;
  end

  // ---- stage B: leading one, normalize, table lookup
  logic [3:0]  p_nxt;
  logic [15:0] m_nxt;
  logic [15:0] lo_nxt, hi_nxt;
  logic [5:0]  idx;

  always_comb begin
    p_nxt = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (x_a_r[k]) p_nxt = 4'(k);
    end
    m_nxt  = x_a_r << (4'd15 - p_nxt);
    idx    = {1'b0, m_nxt[14:10]};
    lo_nxt = lmq_pkg::ln_tab(idx);
    hi_nxt = lmq_pkg::ln_tab(idx + 6'd1);
  end

  lmq_pkg::status_t   st_b_r;
  logic [3:0]         p_b_r;
  logic [15:0]        lo_b_r;
  logic [10:0]        diff_b_r;
  logic [9:0]         frac_b_r;
  logic               small_b_r;
  logic signed [23:0] w_b_r;

  always_ff @(posedge clk) begin
    st_b_r    <= st_a_r;
    p_b_r     <= p_nxt;
    lo_b_r    <= lo_nxt;
    diff_b_r  <= 11'(hi_nxt - lo_nxt);
    frac_b_r  <= m_nxt[9:0];
    small_b_r <= small_a_r;
    w_b_r     <= w_a_r;
  end

  // ---- stage C: octave base and rounded interpolation
  logic [20:0] interp_prod;
  logic [19:0] base_nxt;

  always_comb begin
    interp_prod = 21'(diff_b_r) * 21'(frac_b_r) + 21'd512;
    base_nxt    = 20'(p_b_r - 4'd4) * 20'(lmq_pkg::LN2_Q16) + 20'(lo_b_r);
  end

  lmq_pkg::status_t   st_c_r;
  logic [19:0]        base_c_r;
  logic [10:0]        interp_c_r;
  logic               small_c_r;
  logic signed [23:0] w_c_r;

  always_ff @(posedge clk) begin
    st_c_r     <= st_b_r;
    base_c_r   <= base_nxt;
    interp_c_r <= interp_prod[20:10];
    small_c_r  <= small_b_r;
    w_c_r      <= w_b_r;
  end

  // ---- stage D: u = ln + dac, or -1.0 for tiny x
  logic [19:0] ln_c;
  logic [24:0] u_nxt;

  always_comb begin
    ln_c = base_c_r + 20'(interp_c_r);
    if (small_c_r) begin
      u_nxt = lmq_pkg::U_NEG_ONE;
    end else begin
      u_nxt = {5'b00000, ln_c} + {tof_dac_r[23], tof_dac_r};
    end
  end

  lmq_pkg::status_t   st_d_r;
  logic signed [24:0] u_d_r;
  logic signed [23:0] w_d_r;

  always_ff @(posedge clk) begin
    st_d_r <= st_c_r;
    u_d_r  <= $signed(u_nxt);
    w_d_r  <= w_c_r;
  end

  // ---- stage E: calibration products
  logic signed [55:0] pw_nxt;
  logic signed [56:0] pu_nxt;

  assign pw_nxt = $signed(coef_w_r) * w_d_r;
  assign pu_nxt = $signed(coef_u_r) * u_d_r;

  lmq_pkg::status_t   st_e_r;
  logic signed [55:0] pw_e_r;
  logic signed [56:0] pu_e_r;

  always_ff @(posedge clk) begin
    st_e_r <= st_d_r;
    pw_e_r <= pw_nxt;
    pu_e_r <= pu_nxt;
  end

  // ---- stage F: sum in Q.32, round half up to Q.8
  logic [59:0] sum_nxt;

  assign sum_nxt = {{12{coef_const_r[31]}}, coef_const_r, 16'h0000} +
                   {{4{pw_e_r[55]}}, pw_e_r} +
                   {{3{pu_e_r[56]}}, pu_e_r} +
                   60'h0000_0000_080_0000;

  lmq_pkg::status_t   st_f_r;
  logic signed [35:0] r_f_r;

  always_ff @(posedge clk) begin
    st_f_r <= st_e_r;
    r_f_r  <= $signed(sum_nxt[59:24]);
  end

  // ---- output stage: result window
  logic signed [35:0] wmin, wmax;
  lmq_pkg::status_t   st_out_nxt;

  always_comb begin
    wmin = $signed({{12{mq_window_r[23]}}, mq_window_r[23:0]});
    wmax = $signed({{12{mq_window_r[47]}}, mq_window_r[47:24]});
    if (st_f_r != lmq_pkg::ST_OK) begin
      st_out_nxt = st_f_r;
    end else if (r_f_r < wmin) begin
      st_out_nxt = lmq_pkg::ST_MQ_UNDER;
    end else if (r_f_r > wmax) begin
      st_out_nxt = lmq_pkg::ST_MQ_OVER;
    end else begin
      st_out_nxt = lmq_pkg::ST_OK;
    end
  end

  lmq_pkg::status_t   out_status_r;
  logic signed [23:0] out_mq_value_r;

  always_ff @(posedge clk) begin
    out_status_r   <= st_out_nxt;
    out_mq_value_r <= (st_out_nxt == lmq_pkg::ST_OK) ? r_f_r[23:0] : 24'sd0;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_mq_value = out_mq_value_r;

  // ---- assertions
  logic fail_beat;
  logic ok_stage_f;
  logic in_window;

  assign fail_beat  = out_valid && (out_status != lmq_pkg::ST_OK);
  assign ok_stage_f = vf_r && (st_out_nxt == lmq_pkg::ST_OK);
  assign in_window  = ($signed(out_mq_value) >= $signed(mq_window_r[23:0])) &&
                      ($signed(out_mq_value) <= $signed(mq_window_r[47:24]));

`include "log_mass_per_charge_channel_assert.svh"

  `LMQ_ASSERT_IMPL(a_latency, start && !busy, ##7 out_valid)
  `LMQ_ASSERT_IMPL(a_zero_on_fail, fail_beat, out_mq_value == 24'sd0)
  `LMQ_ASSERT_NEXT(a_ok_in_window, ok_stage_f, in_window)

endmodule
